### rtl/core/dsd_pkg.sv
// Shared types, constants and the power-of-ten table for the decimal divider.
// No dependencies.
package dsd_pkg;

    localparam int MAX_POW10  = 18;
    localparam int SIG_W      = 64;
    localparam int SCALE_W    = 16;
    localparam int K_W        = SCALE_W + 2;
    localparam int POW_IDX_W  = 5;
    localparam int DIV_STEPS  = SIG_W;
    localparam logic [2:0] MODE_HALF_UP = 3'd4;

    localparam logic [1:0] CFG_RES_SCALE     = 2'd0;
    localparam logic [1:0] CFG_ROUNDING_MODE = 2'd1;

    localparam logic [SIG_W-1:0] SIG_MIN_MAG = {1'b1, {(SIG_W-1){1'b0}}};
    localparam logic [SIG_W-1:0] SIG_MAX_POS = {1'b0, {(SIG_W-1){1'b1}}};

    // Sideband that travels with every item through the pipe.
    typedef struct packed {
        logic                 valid;
        logic                 neg;       // quotient sign
        logic                 a_neg;     // dividend sign, picks the clamp limit
        logic                 sat;
        logic                 dbz;
        logic [POW_IDX_W-1:0] kup;       // number of x10 steps
        logic                 down;      // scale down by 10^pidx afterwards
        logic [POW_IDX_W-1:0] pidx;
        logic                 round_en;
        logic [SCALE_W-1:0]   scale;
    } t_side;

    function automatic logic [SIG_W-1:0] pow10(input logic [POW_IDX_W-1:0] idx);
        logic [SIG_W-1:0] v;
        case (idx)
            5'd0:    v = 64'd1;
            5'd1:    v = 64'd10;
            5'd2:    v = 64'd100;
            5'd3:    v = 64'd1000;
            5'd4:    v = 64'd10000;
            5'd5:    v = 64'd100000;
            5'd6:    v = 64'd1000000;
            5'd7:    v = 64'd10000000;
            5'd8:    v = 64'd100000000;
            5'd9:    v = 64'd1000000000;
            5'd10:   v = 64'd10000000000;
            5'd11:   v = 64'd100000000000;
            5'd12:   v = 64'd1000000000000;
            5'd13:   v = 64'd10000000000000;
            5'd14:   v = 64'd100000000000000;
            5'd15:   v = 64'd1000000000000000;
            5'd16:   v = 64'd10000000000000000;
            5'd17:   v = 64'd100000000000000000;
            5'd18:   v = 64'd1000000000000000000;
            default: v = 64'd1;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/decimal_scaled_divide_core.sv
// Top level of the pipelined decimal divider with target-scale rounding.
// Depends on dsd_pkg, dsd_scale_step and dsd_div_step.
//
// Usage:
//   Command channel: an operand pair transfers at a rising edge with start
//   high and busy low. busy is always low, so a new pair may enter every
//   cycle; throughput is one item per clock.
//   Result channel: o_strobe is high for exactly one cycle per item, with
//   quotient, scale and flags on the result ports in that cycle. There is no
//   back-pressure; the receiver must take every result as it appears.
//   Pipeline: 148 register stages, the first loaded at the transfer edge:
//   1 decode stage, 18 up-scale (x10) stages, 64 stages of the main restoring
//   divider, 64 stages of the divide-by-10^m divider, 1 output stage.
//   Config: result scale (index 0) and rounding_mode (index 1) are written
//   through the cfg valid/ready channel, always ready. Values are sampled as
//   an item enters, so writes belong in idle periods.
//   Reset (synchronous, active low) clears all pipe valid bits and returns
//   the result scale to 0 and rounding_mode to half-up (4).
module decimal_scaled_divide_core import dsd_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [SIG_W-1:0]   i_dividend_sig,
    input  logic signed [SCALE_W-1:0] i_dividend_scale,
    input  logic signed [SIG_W-1:0]   i_divisor_sig,
    input  logic signed [SCALE_W-1:0] i_divisor_scale,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [1:0]                i_cfg_index,
    input  logic [SCALE_W-1:0]        i_cfg_data,
    output logic                      o_strobe,
    output logic signed [SIG_W-1:0]   o_quotient_sig,
    output logic signed [SCALE_W-1:0] o_quotient_scale,
    output logic                      o_divide_by_zero,
    output logic                      o_saturated
);
    // config registers
    logic [SCALE_W-1:0] r_res_scale;
    logic [2:0]         r_rounding_mode;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_scale     <= '0;
            r_rounding_mode <= MODE_HALF_UP;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_RES_SCALE:     r_res_scale     <= i_cfg_data;
                CFG_ROUNDING_MODE: r_rounding_mode <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // decode: shift amount k, magnitudes, signs
    logic signed [K_W-1:0] k;
    logic [K_W-1:0]        k_neg;
    logic [SIG_W-1:0]      a_mag, b_mag;
    t_side                 n_dec;

    always_comb begin
        k = K_W'(signed'(r_res_scale))
            - (K_W'(i_dividend_scale) - K_W'(i_divisor_scale));
        k_neg = -k;
        a_mag = i_dividend_sig[SIG_W-1] ? -i_dividend_sig : i_dividend_sig;
        b_mag = i_divisor_sig[SIG_W-1]  ? -i_divisor_sig  : i_divisor_sig;
        n_dec          = '0;
        n_dec.valid    = start && !busy;
        n_dec.a_neg    = i_dividend_sig[SIG_W-1];
        n_dec.neg      = i_dividend_sig[SIG_W-1] ^ i_divisor_sig[SIG_W-1];
        n_dec.dbz      = (i_divisor_sig == '0);
        n_dec.scale    = r_res_scale;
        if (k >= 0 && k <= K_W'(MAX_POW10)) begin
            n_dec.kup = k[POW_IDX_W-1:0];
        end
        if (k < 0 && k >= -K_W'(MAX_POW10)) begin
            n_dec.down     = 1'b1;
            n_dec.pidx     = k_neg[POW_IDX_W-1:0];
            n_dec.round_en = (r_rounding_mode == MODE_HALF_UP);
        end
    end

    t_side            r_dec;
    logic [SIG_W-1:0] r_a, r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec <= '0;
        end else begin
            r_dec <= n_dec;
        end
        r_a   <= a_mag;
        r_b   <= b_mag;
    end

    // up-scale chain: dividend times 10^kup, clamped
    t_side            sc_side [0:MAX_POW10];
    logic [SIG_W-1:0] sc_val  [0:MAX_POW10];
    logic [SIG_W-1:0] sc_den  [0:MAX_POW10];

    assign sc_side[0] = r_dec;
    assign sc_val[0]  = r_a;
    assign sc_den[0]  = r_b;

    for (genvar j = 0; j < MAX_POW10; j++) begin : g_scale
        dsd_scale_step u_step (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_step (POW_IDX_W'(j)),
            .i_side (sc_side[j]),
            .i_val  (sc_val[j]),
            .i_den  (sc_den[j]),
            .o_side (sc_side[j+1]),
            .o_val  (sc_val[j+1]),
            .o_den  (sc_den[j+1])
        );
    end

    // main divider: |a| * 10^kup / |b|
    t_side            d1_side [0:DIV_STEPS];
    logic [SIG_W-1:0] d1_num  [0:DIV_STEPS];
    logic [SIG_W-1:0] d1_rem  [0:DIV_STEPS];
    logic [SIG_W-1:0] d1_den  [0:DIV_STEPS];

    assign d1_side[0] = sc_side[MAX_POW10];
    assign d1_num[0]  = sc_val[MAX_POW10];
    assign d1_rem[0]  = '0;
    assign d1_den[0]  = sc_den[MAX_POW10];

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div1
        dsd_div_step u_step (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_side (d1_side[j]),
            .i_num  (d1_num[j]),
            .i_rem  (d1_rem[j]),
            .i_den  (d1_den[j]),
            .o_side (d1_side[j+1]),
            .o_num  (d1_num[j+1]),
            .o_rem  (d1_rem[j+1]),
            .o_den  (d1_den[j+1])
        );
    end

    // second divider: whole / 10^pidx (divisor 1 when not scaling down)
    t_side            d2_side [0:DIV_STEPS];
    logic [SIG_W-1:0] d2_num  [0:DIV_STEPS];
    logic [SIG_W-1:0] d2_rem  [0:DIV_STEPS];
    logic [SIG_W-1:0] d2_den  [0:DIV_STEPS];

    assign d2_side[0] = d1_side[DIV_STEPS];
    assign d2_num[0]  = d1_num[DIV_STEPS];
    assign d2_rem[0]  = '0;
    assign d2_den[0]  = d1_side[DIV_STEPS].down ? pow10(d1_side[DIV_STEPS].pidx)
                                                : pow10('0);

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div2
        dsd_div_step u_step (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_side (d2_side[j]),
            .i_num  (d2_num[j]),
            .i_rem  (d2_rem[j]),
            .i_den  (d2_den[j]),
            .o_side (d2_side[j+1]),
            .o_num  (d2_num[j+1]),
            .o_rem  (d2_rem[j+1]),
            .o_den  (d2_den[j+1])
        );
    end

    // output stage: half-up round, positive overflow clamp, sign, zero divisor
    t_side            fin;
    logic [SIG_W-1:0] q_mag, n_q;
    logic             n_sat, round_up;
    logic             r_strobe, r_dbz, r_sat;
    logic [SIG_W-1:0] r_q;
    logic [SCALE_W-1:0] r_scale;

    always_comb begin
        fin      = d2_side[DIV_STEPS];
        round_up = fin.round_en && (d2_rem[DIV_STEPS] >= (d2_den[DIV_STEPS] >> 1));
        q_mag    = d2_num[DIV_STEPS] + SIG_W'(round_up);
        n_sat    = fin.sat;
        if (!fin.neg && q_mag[SIG_W-1]) begin
            q_mag = SIG_MAX_POS;
            n_sat = 1'b1;
        end
        n_q = fin.neg ? -q_mag : q_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= fin.valid;
        end
        r_dbz   <= fin.dbz;
        r_sat   <= fin.dbz ? 1'b0 : n_sat;
        r_q     <= fin.dbz ? '0 : n_q;
        r_scale <= fin.dbz ? '0 : fin.scale;
    end

    assign o_strobe         = r_strobe;
    assign o_quotient_sig   = r_q;
    assign o_quotient_scale = r_scale;
    assign o_divide_by_zero = r_dbz;
    assign o_saturated      = r_sat;

    // checks
    a_dbz_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_divide_by_zero |->
            o_quotient_sig == '0 && o_quotient_scale == '0 && !o_saturated)
        else $error("zero divisor result not cleared");

    a_out_follows_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin.valid |=> o_strobe)
        else $error("pipe item lost at output");

    a_round_only_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin.valid && fin.round_en |-> fin.down)
        else $error("rounding enabled without scale-down");
endmodule

### rtl/core/dsd_scale_step.sv
// One x10 up-scaling stage with clamp to the signed limit.
// Depends on dsd_pkg.
module dsd_scale_step import dsd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [POW_IDX_W-1:0] i_step,
    input  t_side                i_side,
    input  logic [SIG_W-1:0]     i_val,
    input  logic [SIG_W-1:0]     i_den,
    output t_side                o_side,
    output logic [SIG_W-1:0]     o_val,
    output logic [SIG_W-1:0]     o_den
);
    t_side            r_side, n_side;
    logic [SIG_W-1:0] r_val, n_val, r_den;
    logic [SIG_W+3:0] times10;
    logic [SIG_W-1:0] lim;

    always_comb begin
        n_side  = i_side;
        lim     = i_side.a_neg ? SIG_MIN_MAG : SIG_MAX_POS;
        times10 = {i_val, 3'b000} + {3'b000, i_val, 1'b0};
        n_val   = i_val;
        if (i_step < i_side.kup) begin
            if (times10 > {4'd0, lim}) begin
                n_val      = lim;
                n_side.sat = 1'b1;
            end else begin
                n_val = times10[SIG_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else begin
            r_side <= n_side;
        end
        r_val  <= n_val;
        r_den  <= i_den;
    end

    assign o_side = r_side;
    assign o_val  = r_val;
    assign o_den  = r_den;
endmodule

### rtl/core/dsd_div_step.sv
// One restoring divide step: one quotient bit per stage.
// Depends on dsd_pkg.
module dsd_div_step import dsd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_side            i_side,
    input  logic [SIG_W-1:0] i_num,
    input  logic [SIG_W-1:0] i_rem,
    input  logic [SIG_W-1:0] i_den,
    output t_side            o_side,
    output logic [SIG_W-1:0] o_num,
    output logic [SIG_W-1:0] o_rem,
    output logic [SIG_W-1:0] o_den
);
    t_side            r_side;
    logic [SIG_W-1:0] r_num, r_rem, r_den, n_num, n_rem;
    logic [SIG_W:0]   shifted, diff;
    logic             ge;

    always_comb begin
        shifted = {i_rem, i_num[SIG_W-1]};
        diff    = shifted - {1'b0, i_den};
        ge      = shifted >= {1'b0, i_den};
        n_rem   = ge ? diff[SIG_W-1:0] : shifted[SIG_W-1:0];
        n_num   = {i_num[SIG_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else begin
            r_side <= i_side;
        end
        r_num  <= n_num;
        r_rem  <= n_rem;
        r_den  <= i_den;
    end

    assign o_side = r_side;
    assign o_num  = r_num;
    assign o_rem  = r_rem;
    assign o_den  = r_den;
endmodule
